// ----- hw/rtl/ccs_pkg.sv -----
// Shared constants, types and helper functions for the center-crop scaler.
// Used by ccs_div, ccs_store and center_crop_nearest_scaler; depends on nothing.
package ccs_pkg;

    localparam int MAX_SOURCE_DIM = 256;
    localparam int MAX_TARGET_DIM = 128;

    localparam int SRC_W   = 9;
    localparam int TGT_W   = 8;
    localparam int COORD_W = 8;
    localparam int PIX_W   = 16;
    localparam int OP_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam int ADDR_W  = 2 * COORD_W;
    localparam int EPOCH_W = 8;
    localparam int WORD_W  = EPOCH_W + PIX_W;
    localparam int PROD_W  = SRC_W + TGT_W;

    localparam int DIV_NUM_W      = 16;
    localparam int DIV_DEN_W      = 8;
    localparam int DIV_RADIX_BITS = 2;
    localparam int DIV_CYCLES     = DIV_NUM_W / DIV_RADIX_BITS;
    localparam int DIV_CNT_W      = $clog2(DIV_CYCLES);

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_FRAME = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HEIGHT = 2'd3;

    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

    typedef struct packed {
        logic              wr;
        logic              rd;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] wdata;
    } t_store_req;

    function automatic logic [SRC_W-1:0] clamp_src(input logic [SRC_W-1:0] v);
        logic [SRC_W-1:0] r;
        if (v == '0) begin
            r = SRC_W'(1);
        end else if (v > SRC_W'(MAX_SOURCE_DIM)) begin
            r = SRC_W'(MAX_SOURCE_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [TGT_W-1:0] clamp_tgt(input logic [TGT_W-1:0] v);
        logic [TGT_W-1:0] r;
        if (v == '0) begin
            r = TGT_W'(1);
        end else if (v > TGT_W'(MAX_TARGET_DIM)) begin
            r = TGT_W'(MAX_TARGET_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/ccs_div.sv -----
// Iterative unsigned divider that resolves two quotient bits per cycle.
// Depends on ccs_pkg for its widths and step count.
module ccs_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [ccs_pkg::DIV_NUM_W-1:0]     i_num,
    input  logic [ccs_pkg::DIV_DEN_W-1:0]     i_den,
    output logic                              o_busy,
    output logic [ccs_pkg::DIV_NUM_W-1:0]     o_quo
);

    logic                              r_busy;
    logic [ccs_pkg::DIV_CNT_W-1:0]     r_cnt;
    logic [ccs_pkg::DIV_NUM_W-1:0]     r_acc;
    logic [ccs_pkg::DIV_DEN_W-1:0]     r_rem;
    logic [ccs_pkg::DIV_DEN_W-1:0]     r_den;
    logic [ccs_pkg::DIV_NUM_W-1:0]     n_acc;
    logic [ccs_pkg::DIV_DEN_W-1:0]     n_rem;

    always_comb begin
        logic [ccs_pkg::DIV_DEN_W:0] v_trial;
        n_acc = r_acc;
        n_rem = r_rem;
        for (int k = 0; k < ccs_pkg::DIV_RADIX_BITS; k++) begin
            v_trial = {n_rem, n_acc[ccs_pkg::DIV_NUM_W-1]};
            n_acc   = {n_acc[ccs_pkg::DIV_NUM_W-2:0], 1'b0};
            if (v_trial >= {1'b0, r_den}) begin
                v_trial  = v_trial - {1'b0, r_den};
                n_acc[0] = 1'b1;
            end
            n_rem = v_trial[ccs_pkg::DIV_DEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + ccs_pkg::DIV_CNT_W'(1);
            if (r_cnt == ccs_pkg::DIV_CNT_W'(ccs_pkg::DIV_CYCLES - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_acc;

endmodule

// ----- hw/rtl/ccs_store.sv -----
// Source image memory: one word per pixel holding a frame epoch and the RGB565 value.
// Includes the clearing sweep run after reset and on epoch wrap; depends on ccs_pkg.
module ccs_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ccs_pkg::t_store_req           i_req,
    input  logic                          i_clear_start,
    output logic                          o_clear_busy,
    output logic [ccs_pkg::WORD_W-1:0]    o_rdata
);

    localparam int DEPTH = 1 << ccs_pkg::ADDR_W;

    logic [ccs_pkg::WORD_W-1:0] mem [DEPTH];
    logic [ccs_pkg::WORD_W-1:0] r_rdata;
    logic                       r_clr_busy;
    logic [ccs_pkg::ADDR_W-1:0] r_clr_addr;
    logic                       wr_en;
    logic [ccs_pkg::ADDR_W-1:0] wr_addr;
    logic [ccs_pkg::WORD_W-1:0] wr_data;

    assign wr_en   = r_clr_busy | i_req.wr;
    assign wr_addr = r_clr_busy ? r_clr_addr : i_req.addr;
    assign wr_data = r_clr_busy ? '0 : i_req.wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + ccs_pkg::ADDR_W'(1);
            if (r_clr_addr == '1) begin
                r_clr_busy <= 1'b0;
            end
        end else if (i_clear_start) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_req.rd) begin
            r_rdata <= mem[i_req.addr];
        end
    end

    assign o_clear_busy = r_clr_busy;
    assign o_rdata      = r_rdata;

endmodule

// ----- hw/rtl/center_crop_nearest_scaler.sv -----
// Top level of the center-crop nearest-neighbor scaler over an RGB565 source store.
// Depends on ccs_pkg, ccs_div and ccs_store.
//
// The block holds a source image of up to 256 x 256 pixels and answers reads of a
// scaled target image by sampling a centered, aspect-matched crop of it. One transaction
// is handled at a time. A read inside the target size is served by two 16-bit dividers
// that run in parallel and resolve two quotient bits per cycle, followed by one memory
// read; a read outside the target size uses neither the dividers nor the memory. The
// first read inside the target size after reset or a configuration write first
// recomputes the crop on the same divider. A read also waits for as long as the previous
// result is held in the output register. After reset, and on every 255th frame start,
// the store is swept clear, and the input is stalled while the sweep runs. A finished
// result waits in an output register while the next transaction is accepted.
// Configuration is always ready.
module center_crop_nearest_scaler (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [ccs_pkg::OP_W-1:0]          i_op,
    input  logic [ccs_pkg::COORD_W-1:0]       i_coord_x,
    input  logic [ccs_pkg::COORD_W-1:0]       i_coord_y,
    input  logic [ccs_pkg::PIX_W-1:0]         i_pixel_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [ccs_pkg::PIX_W-1:0]         o_pixel_out,
    output logic                              o_out_of_range,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ccs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ccs_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_MUL    = 3'd2;
    localparam logic [2:0] ST_DSTART = 3'd3;
    localparam logic [2:0] ST_DWAIT  = 3'd4;
    localparam logic [2:0] ST_RD     = 3'd5;
    localparam logic [2:0] ST_RESP   = 3'd6;

    logic [2:0]                          r_state;
    logic [ccs_pkg::OP_W-1:0]            r_op;
    logic [ccs_pkg::COORD_W-1:0]         r_cx;
    logic [ccs_pkg::COORD_W-1:0]         r_cy;
    logic [ccs_pkg::PIX_W-1:0]           r_pv;
    logic [ccs_pkg::SRC_W-1:0]           r_src_w;
    logic [ccs_pkg::SRC_W-1:0]           r_src_h;
    logic [ccs_pkg::TGT_W-1:0]           r_tgt_w;
    logic [ccs_pkg::TGT_W-1:0]           r_tgt_h;
    logic                                r_crop_ok;
    logic                                r_crop_phase;
    logic                                r_wide;
    logic [ccs_pkg::SRC_W-1:0]           r_cw;
    logic [ccs_pkg::SRC_W-1:0]           r_ch;
    logic [ccs_pkg::COORD_W-1:0]         r_ox;
    logic [ccs_pkg::COORD_W-1:0]         r_oy;
    logic [ccs_pkg::EPOCH_W-1:0]         r_epoch;
    logic [ccs_pkg::DIV_NUM_W-1:0]       r_nx;
    logic [ccs_pkg::DIV_NUM_W-1:0]       r_ny;
    logic [ccs_pkg::DIV_DEN_W-1:0]       r_dx;
    logic [ccs_pkg::DIV_DEN_W-1:0]       r_dy;
    logic [ccs_pkg::PIX_W-1:0]           r_res_pix;
    logic                                r_res_oor;
    logic                                r_out_valid;
    logic [ccs_pkg::PIX_W-1:0]           r_out_pix;
    logic                                r_out_oor;

    logic [ccs_pkg::SRC_W-1:0]           sw;
    logic [ccs_pkg::SRC_W-1:0]           sh;
    logic [ccs_pkg::TGT_W-1:0]           tw;
    logic [ccs_pkg::TGT_W-1:0]           th;
    logic [ccs_pkg::PROD_W-1:0]          prod_a;
    logic [ccs_pkg::PROD_W-1:0]          prod_b;
    logic [ccs_pkg::PROD_W-1:0]          prod_x;
    logic [ccs_pkg::PROD_W-1:0]          prod_y;
    logic                                wide;
    logic                                wr_in_range;
    logic                                rd_in_range;
    logic                                div_start;
    logic                                div_x_busy;
    logic                                div_y_busy;
    logic [ccs_pkg::DIV_NUM_W-1:0]       div_x_quo;
    logic [ccs_pkg::DIV_NUM_W-1:0]       div_y_quo;
    logic                                div_done;
    logic [ccs_pkg::SRC_W-1:0]           crop_lim;
    logic [ccs_pkg::SRC_W-1:0]           crop_q;
    logic [ccs_pkg::SRC_W-1:0]           new_cw;
    logic [ccs_pkg::SRC_W-1:0]           new_ch;
    logic [ccs_pkg::SRC_W-1:0]           diff_w;
    logic [ccs_pkg::SRC_W-1:0]           diff_h;
    logic [ccs_pkg::SRC_W-1:0]           sum_x;
    logic [ccs_pkg::SRC_W-1:0]           sum_y;
    logic                                clear_start;
    logic                                clear_busy;
    logic [ccs_pkg::WORD_W-1:0]          store_rdata;
    logic                                in_accept;
    logic                                out_accept;
    logic                                out_free;
    ccs_pkg::t_store_req                 store_req;

    assign sw = ccs_pkg::clamp_src(r_src_w);
    assign sh = ccs_pkg::clamp_src(r_src_h);
    assign tw = ccs_pkg::clamp_tgt(r_tgt_w);
    assign th = ccs_pkg::clamp_tgt(r_tgt_h);

    assign prod_a = ccs_pkg::PROD_W'(sw) * ccs_pkg::PROD_W'(th);
    assign prod_b = ccs_pkg::PROD_W'(sh) * ccs_pkg::PROD_W'(tw);
    assign prod_x = ccs_pkg::PROD_W'(r_cx) * ccs_pkg::PROD_W'(r_cw);
    assign prod_y = ccs_pkg::PROD_W'(r_cy) * ccs_pkg::PROD_W'(r_ch);
    assign wide   = (prod_a >= prod_b);

    assign wr_in_range = (ccs_pkg::SRC_W'(r_cx) < sw) && (ccs_pkg::SRC_W'(r_cy) < sh);
    assign rd_in_range = (r_cx < tw) && (r_cy < th);

    assign div_start = (r_state == ST_DSTART);
    assign div_done  = !div_x_busy && !div_y_busy;

    assign crop_lim = r_wide ? sw : sh;
    assign crop_q   = (div_x_quo == '0) ? ccs_pkg::SRC_W'(1) :
                      (div_x_quo > ccs_pkg::DIV_NUM_W'(crop_lim)) ? crop_lim :
                      div_x_quo[ccs_pkg::SRC_W-1:0];
    assign new_cw   = r_wide ? crop_q : sw;
    assign new_ch   = r_wide ? sh : crop_q;
    assign diff_w   = sw - new_cw;
    assign diff_h   = sh - new_ch;

    assign sum_x = ccs_pkg::SRC_W'(r_ox) + ccs_pkg::SRC_W'(div_x_quo[ccs_pkg::COORD_W-1:0]);
    assign sum_y = ccs_pkg::SRC_W'(r_oy) + ccs_pkg::SRC_W'(div_y_quo[ccs_pkg::COORD_W-1:0]);

    assign clear_start = (r_state == ST_EXEC) && (r_op == ccs_pkg::OP_FRAME) &&
                         (r_epoch == ccs_pkg::EPOCH_LAST);

    assign o_in_stall  = (r_state != ST_IDLE) || clear_busy;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_accept  = r_out_valid && !i_out_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        store_req = '0;
        if (r_state == ST_EXEC && r_op == ccs_pkg::OP_WRITE && wr_in_range) begin
            store_req.wr    = 1'b1;
            store_req.addr  = {r_cy, r_cx};
            store_req.wdata = {r_epoch, r_pv};
        end else if (r_state == ST_DWAIT && !r_crop_phase && div_done) begin
            store_req.rd   = 1'b1;
            store_req.addr = {sum_y[ccs_pkg::COORD_W-1:0], sum_x[ccs_pkg::COORD_W-1:0]};
        end
    end

    ccs_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_nx),
        .i_den   (r_dx),
        .o_busy  (div_x_busy),
        .o_quo   (div_x_quo)
    );

    ccs_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_ny),
        .i_den   (r_dy),
        .o_busy  (div_y_busy),
        .o_quo   (div_y_quo)
    );

    ccs_store u_store (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (store_req),
        .i_clear_start (clear_start),
        .o_clear_busy  (clear_busy),
        .o_rdata       (store_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= ccs_pkg::SRC_W'(256);
            r_src_h <= ccs_pkg::SRC_W'(256);
            r_tgt_w <= ccs_pkg::TGT_W'(80);
            r_tgt_h <= ccs_pkg::TGT_W'(80);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ccs_pkg::CFG_SOURCE_WIDTH:  r_src_w <= i_cfg_data;
                ccs_pkg::CFG_SOURCE_HEIGHT: r_src_h <= i_cfg_data;
                ccs_pkg::CFG_TARGET_WIDTH:  r_tgt_w <= i_cfg_data[ccs_pkg::TGT_W-1:0];
                ccs_pkg::CFG_TARGET_HEIGHT: r_tgt_h <= i_cfg_data[ccs_pkg::TGT_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_crop_ok    <= 1'b0;
            r_crop_phase <= 1'b0;
            r_epoch      <= ccs_pkg::EPOCH_FIRST;
        end else begin
            if (i_cfg_valid) begin
                r_crop_ok <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    unique case (r_op)
                        ccs_pkg::OP_WRITE: begin
                            r_state <= ST_IDLE;
                        end
                        ccs_pkg::OP_READ: begin
                            if (!rd_in_range) begin
                                r_state <= ST_RESP;
                            end else if (!r_crop_ok) begin
                                r_crop_phase <= 1'b1;
                                r_state      <= ST_DSTART;
                            end else begin
                                r_state <= ST_MUL;
                            end
                        end
                        ccs_pkg::OP_FRAME: begin
                            if (r_epoch == ccs_pkg::EPOCH_LAST) begin
                                r_epoch <= ccs_pkg::EPOCH_FIRST;
                            end else begin
                                r_epoch <= r_epoch + ccs_pkg::EPOCH_W'(1);
                            end
                            r_state <= ST_IDLE;
                        end
                        default: begin
                            r_state <= ST_IDLE;
                        end
                    endcase
                end
                ST_MUL: begin
                    r_state <= ST_DSTART;
                end
                ST_DSTART: begin
                    r_state <= ST_DWAIT;
                end
                ST_DWAIT: begin
                    if (div_done) begin
                        if (r_crop_phase) begin
                            r_crop_phase <= 1'b0;
                            r_crop_ok    <= 1'b1;
                            r_state      <= ST_MUL;
                        end else begin
                            r_state <= ST_RD;
                        end
                    end
                end
                ST_RD: begin
                    r_state <= ST_RESP;
                end
                ST_RESP: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op <= i_op;
            r_cx <= i_coord_x;
            r_cy <= i_coord_y;
            r_pv <= i_pixel_value;
        end
        if (r_state == ST_EXEC && r_op == ccs_pkg::OP_READ) begin
            r_wide    <= wide;
            r_nx      <= wide ? prod_b[ccs_pkg::DIV_NUM_W-1:0] : prod_a[ccs_pkg::DIV_NUM_W-1:0];
            r_dx      <= wide ? th : tw;
            r_res_pix <= '0;
            r_res_oor <= 1'b1;
        end
        if (r_state == ST_MUL) begin
            r_nx <= prod_x[ccs_pkg::DIV_NUM_W-1:0];
            r_ny <= prod_y[ccs_pkg::DIV_NUM_W-1:0];
            r_dx <= tw;
            r_dy <= th;
        end
        if (r_state == ST_DWAIT && div_done && r_crop_phase) begin
            r_cw <= new_cw;
            r_ch <= new_ch;
            r_ox <= diff_w[ccs_pkg::SRC_W-1:1];
            r_oy <= diff_h[ccs_pkg::SRC_W-1:1];
        end
        if (r_state == ST_RD) begin
            r_res_oor <= 1'b0;
            if (store_rdata[ccs_pkg::WORD_W-1:ccs_pkg::PIX_W] == r_epoch) begin
                r_res_pix <= store_rdata[ccs_pkg::PIX_W-1:0];
            end else begin
                r_res_pix <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_RESP && out_free) begin
            r_out_valid <= 1'b1;
        end else if (out_accept) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RESP && out_free) begin
            r_out_pix <= r_res_pix;
            r_out_oor <= r_res_oor;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pixel_out    = r_out_pix;
    assign o_out_of_range = r_out_oor;

    a_epoch_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_epoch != '0)
        else $error("Frame epoch reached the value that marks cleared entries.");

    a_result_from_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_RESP))
        else $error("Output became valid without a finished read.");

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> (!div_x_busy && !div_y_busy))
        else $error("Divider started while still busy.");

    a_oor_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_of_range) |-> (o_pixel_out == '0))
        else $error("Out-of-range transaction returned a nonzero pixel.");

endmodule
